// ===== rtl/core/hta_pkg.sv =====
`default_nettype none
package hta_pkg;

	// quality word bits
	localparam int unsigned APOD_BIT  = 8;
	localparam int unsigned LOWAP_BIT = 12;
	localparam logic [15:0] APOD_MASK  = 16'(1) << APOD_BIT;
	localparam logic [15:0] LOWAP_MASK = 16'(1) << LOWAP_BIT;

	// factor format
	localparam int unsigned FRAC_BITS = 24;
	localparam int unsigned W_SHIFT   = 32 - FRAC_BITS;
	localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
	localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
	// factor * 1e6 <= 2^24 holds for factors up to this value
	localparam logic [24:0] LOW_FACTOR_MAX = 25'd16;

	// shared divider shape
	localparam int unsigned NUM_W = 56;
	localparam int unsigned DEN_W = 25;
	localparam int unsigned QUO_W = 33;

	// sine series, horner from the x^9 term down
	localparam int unsigned HORNER_STEPS = 4;
	localparam logic [6:0] HORNER_DIV [HORNER_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
		32'(64'h1_0000_0000 / 72),
		32'(64'h1_0000_0000 / 42),
		32'(64'h1_0000_0000 / 20),
		32'(64'h1_0000_0000 / 6)
	};

	// register map
	localparam logic [2:0] CFG_START_INDEX = 3'd0;
	localparam logic [2:0] CFG_END_INDEX   = 3'd1;
	localparam logic [2:0] CFG_WINDOW_LEN  = 3'd2;
	localparam logic [2:0] CFG_USE_MAX     = 3'd3;
	localparam logic [2:0] CFG_INVERSE     = 3'd4;
	localparam logic [2:0] CFG_QUALITY     = 3'd5;
	localparam logic [2:0] CFG_SKIP_MASK   = 3'd6;

	typedef struct packed {
		logic [15:0]        sample_index;
		logic signed [31:0] sample_value;
		logic [15:0]        sample_quality;
		logic               detector_bad;
		logic               sample_bad;
	} hta_in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [15:0]        result_quality;
		logic               result_bad;
		logic               saturated;
		logic               config_error;
	} hta_out_t;

	// per-item context carried down the pipe
	typedef struct packed {
		logic [31:0] value;
		logic [15:0] qual;
		logic        bad;
		logic        err;
		logic        db;
		logic        qmode;
		logic        inv;
		logic        skip;
		logic        neg;
		logic        act;
		logic        refl;
		logic        low;
		logic [31:0] mag;
		logic [31:0] fwd;
	} hta_ctx_t;

endpackage
`default_nettype wire

// ===== rtl/core/hta_div.sv =====
`default_nettype none
module hta_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [hta_pkg::NUM_W-1:0] in_num,
	input  logic [hta_pkg::DEN_W-1:0] in_den,
	input  hta_pkg::hta_ctx_t         in_ctx,
	output logic                      out_valid,
	output logic [hta_pkg::QUO_W-1:0] out_quo,
	output logic                      out_ovf,
	output hta_pkg::hta_ctx_t         out_ctx
);
	import hta_pkg::*;

	// one quotient bit per stage, restoring
	logic             vld_s [QUO_W+1];
	logic [DEN_W-1:0] rem_s [QUO_W+1];
	logic [QUO_W-1:0] low_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];
	hta_ctx_t         ctx_s [QUO_W+1];

	logic [DEN_W:0] trial [QUO_W];
	logic [DEN_W:0] diff  [QUO_W];
	logic           ge    [QUO_W];

	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			trial[k] = {rem_s[k], low_s[k][QUO_W-1]};
			diff[k]  = trial[k] - {1'b0, den_s[k]};
			ge[k]    = trial[k] >= {1'b0, den_s[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUO_W; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < QUO_W; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= DEN_W'(in_num[NUM_W-1:QUO_W]);
		low_s[0] <= in_num[QUO_W-1:0];
		quo_s[0] <= '0;
		den_s[0] <= in_den;
		ovf_s[0] <= DEN_W'(in_num[NUM_W-1:QUO_W]) >= in_den;
		ctx_s[0] <= in_ctx;
		for (int k = 0; k < QUO_W; k++) begin
			rem_s[k+1] <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
			low_s[k+1] <= low_s[k] << 1;
			quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge[k]};
			den_s[k+1] <= den_s[k];
			ovf_s[k+1] <= ovf_s[k];
			ctx_s[k+1] <= ctx_s[k];
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign out_quo   = quo_s[QUO_W];
	assign out_ovf   = ovf_s[QUO_W];
	assign out_ctx   = ctx_s[QUO_W];

endmodule
`default_nettype wire

// ===== rtl/core/hta_sine.sv =====
`default_nettype none
module hta_sine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [31:0]       in_x,
	input  hta_pkg::hta_ctx_t in_ctx,
	output logic              out_valid,
	output logic [24:0]       out_w,
	output hta_pkg::hta_ctx_t out_ctx
);
	import hta_pkg::*;

	// x squared
	logic        sq_v_s1;
	logic [31:0] sq_x_s1;
	logic [31:0] sq_x2_s1;
	hta_ctx_t    sq_ctx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s1 <= 1'b0;
		end else begin
			sq_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sq_x_s1   <= in_x;
		sq_x2_s1  <= 32'((64'(in_x) * 64'(in_x)) >> 32);
		sq_ctx_s1 <= in_ctx;
	end

	// step boundaries
	logic        st_v   [HORNER_STEPS+1];
	logic [31:0] st_x   [HORNER_STEPS+1];
	logic [31:0] st_x2  [HORNER_STEPS+1];
	logic [32:0] st_t   [HORNER_STEPS+1];
	hta_ctx_t    st_ctx [HORNER_STEPS+1];

	assign st_v[0]   = sq_v_s1;
	assign st_x[0]   = sq_x_s1;
	assign st_x2[0]  = sq_x2_s1;
	assign st_t[0]   = ONE_Q32;
	assign st_ctx[0] = sq_ctx_s1;

	// each step: t = 1 - ((x2*t)>>32)/c, multiply, reciprocal, correct
	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
		logic        vld_s1, vld_s2, vld_s3;
		logic [31:0] x_s1, x_s2, x_s3;
		logic [31:0] x2_s1, x2_s2, x2_s3;
		hta_ctx_t    ctx_s1, ctx_s2, ctx_s3;
		logic [31:0] p_s1, p_s2, q0_s2;
		logic [32:0] t_s3;
		logic [31:0] rem_c;
		logic [31:0] q_c;

		always_comb begin
			rem_c = p_s2 - q0_s2 * 32'(HORNER_DIV[j]);
			q_c   = q0_s2 + 32'(rem_c >= 32'(HORNER_DIV[j]));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
				vld_s2 <= 1'b0;
				vld_s3 <= 1'b0;
			end else begin
				vld_s1 <= st_v[j];
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
			end
		end

		always_ff @(posedge clk) begin
			p_s1   <= 32'((65'(st_x2[j]) * 65'(st_t[j])) >> 32);
			x_s1   <= st_x[j];
			x2_s1  <= st_x2[j];
			ctx_s1 <= st_ctx[j];
			q0_s2  <= 32'((64'(p_s1) * 64'(HORNER_RECIP[j])) >> 32);
			p_s2   <= p_s1;
			x_s2   <= x_s1;
			x2_s2  <= x2_s1;
			ctx_s2 <= ctx_s1;
			t_s3   <= ONE_Q32 - 33'(q_c);
			x_s3   <= x_s2;
			x2_s3  <= x2_s2;
			ctx_s3 <= ctx_s2;
		end

		assign st_v[j+1]   = vld_s3;
		assign st_x[j+1]   = x_s3;
		assign st_x2[j+1]  = x2_s3;
		assign st_t[j+1]   = t_s3;
		assign st_ctx[j+1] = ctx_s3;
	end

	// sine, its square, then the factor
	logic        sn_v_s1, sq_v_s2, wt_v_s3;
	logic [31:0] sn_s1, sq_s2;
	hta_ctx_t    sn_ctx_s1, sq_ctx_s2, wt_ctx_s3;
	logic [24:0] wt_s3;
	logic [32:0] w32_c;

	always_comb begin
		w32_c = sq_ctx_s2.refl ? ONE_Q32 - 33'(sq_s2) : 33'(sq_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sn_v_s1 <= 1'b0;
			sq_v_s2 <= 1'b0;
			wt_v_s3 <= 1'b0;
		end else begin
			sn_v_s1 <= st_v[HORNER_STEPS];
			sq_v_s2 <= sn_v_s1;
			wt_v_s3 <= sq_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sn_s1     <= 32'((65'(st_x[HORNER_STEPS]) * 65'(st_t[HORNER_STEPS])) >> 32);
		sn_ctx_s1 <= st_ctx[HORNER_STEPS];
		sq_s2     <= 32'((64'(sn_s1) * 64'(sn_s1)) >> 32);
		sq_ctx_s2 <= sn_ctx_s1;
		wt_s3     <= 25'((34'(w32_c) + (34'd1 << (W_SHIFT - 1))) >> W_SHIFT);
		wt_ctx_s3 <= sq_ctx_s2;
	end

	assign out_valid = wt_v_s3;
	assign out_w     = wt_s3;
	assign out_ctx   = wt_ctx_s3;

endmodule
`default_nettype wire

// ===== rtl/core/hann_taper_apodizer_core.sv =====
`default_nettype none
// hann taper apodizer: one time-stream sample in, one tapered sample out
//
// input: an item is taken at each clock edge with start high; busy stays low,
// so a new item may follow every cycle with no gaps
// output: done is high for one cycle with the result on result; the receiver
// cannot stall, so results leave in order, one per accepted item
// throughput one item per cycle; the pipe is built around two 34-stage
// restoring dividers (taper angle, and the inverse scaling) and the
// 16-stage sine series unit between them
// configuration: cfg_we/cfg_idx/cfg_data write one register per edge; write
// only while no item is in flight
// reset: arst_n clears the pipe valid bits and loads the register defaults
// (end index 65535, quality mode on, all else zero)
module hann_taper_apodizer_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hta_pkg::hta_in_t  item,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [15:0]       cfg_data,
	output logic              done,
	output hta_pkg::hta_out_t result
);
	import hta_pkg::*;

	// configuration registers
	logic [15:0] start_index_q;
	logic [15:0] end_index_q;
	logic [15:0] window_len_q;
	logic        use_max_q;
	logic        inverse_q;
	logic        quality_q;
	logic [15:0] skip_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_index_q <= '0;
			end_index_q   <= 16'hFFFF;
			window_len_q  <= '0;
			use_max_q     <= 1'b0;
			inverse_q     <= 1'b0;
			quality_q     <= 1'b1;
			skip_mask_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_START_INDEX: start_index_q <= cfg_data;
				CFG_END_INDEX:   end_index_q   <= cfg_data;
				CFG_WINDOW_LEN:  window_len_q  <= cfg_data;
				CFG_USE_MAX:     use_max_q     <= cfg_data[0];
				CFG_INVERSE:     inverse_q     <= cfg_data[0];
				CFG_QUALITY:     quality_q     <= cfg_data[0];
				CFG_SKIP_MASK:   skip_mask_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// the pipe takes an item every cycle
	assign busy = 1'b0;

	// stage 1: register the item, work out span, window length and error
	logic [16:0] span_c;
	logic [15:0] len_c;
	logic        err_c;

	always_comb begin
		span_c = {1'b0, end_index_q} - {1'b0, start_index_q} + 17'd1;
		len_c  = use_max_q ? span_c[16:1] : window_len_q;
		err_c  = (start_index_q > end_index_q) ||
		         (!use_max_q && (span_c < {len_c, 1'b0}));
	end

	logic        v_s1;
	hta_in_t     in_s1;
	logic [15:0] len_s1;
	logic        err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		in_s1  <= item;
		len_s1 <= len_c;
		err_s1 <= err_c;
	end

	// stage 2: depth into the window, reflection, marks and skip decision
	logic [15:0] d_c, e_c, depth_c, a_c;
	logic        inspan_c, near_c, in_d_c, in_e_c, refl_c;
	logic [15:0] qual_c;
	logic [31:0] val_c, mag_c;
	hta_ctx_t    ctx_c;

	always_comb begin
		d_c      = in_s1.sample_index - start_index_q;
		e_c      = end_index_q - in_s1.sample_index;
		inspan_c = !err_s1 && (in_s1.sample_index >= start_index_q) &&
		           (in_s1.sample_index <= end_index_q);
		near_c   = ({1'b0, d_c} < {len_s1, 1'b0}) || ({1'b0, e_c} < {len_s1, 1'b0});
		qual_c   = in_s1.sample_quality |
		           ((quality_q && inspan_c && near_c) ? APOD_MASK : 16'd0);
		in_d_c   = d_c < len_s1;
		in_e_c   = e_c < len_s1;
		depth_c  = in_d_c ? d_c : e_c;
		refl_c   = {depth_c, 1'b0} > {1'b0, len_s1};
		a_c      = refl_c ? len_s1 - depth_c : depth_c;
		val_c    = in_s1.sample_value;
		mag_c    = val_c[31] ? 32'd0 - val_c : val_c;

		ctx_c       = '0;
		ctx_c.value = val_c;
		ctx_c.qual  = qual_c;
		ctx_c.bad   = in_s1.sample_bad;
		ctx_c.err   = err_s1;
		ctx_c.db    = in_s1.detector_bad;
		ctx_c.qmode = quality_q;
		ctx_c.inv   = inverse_q;
		ctx_c.skip  = quality_q ? (in_s1.detector_bad || ((qual_c & skip_mask_q) != 16'd0))
		                        : in_s1.sample_bad;
		ctx_c.neg   = val_c[31];
		ctx_c.act   = inspan_c && (in_d_c || in_e_c);
		ctx_c.refl  = refl_c;
		ctx_c.mag   = mag_c;
	end

	logic        v_s2;
	hta_ctx_t    ctx_s2;
	logic [15:0] a_s2, len_s2;

	// stage 3: angle numerator a * pi/2
	logic        v_s3;
	hta_ctx_t    ctx_s3;
	logic [48:0] num_s3;
	logic [15:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= ctx_c;
		a_s2   <= a_c;
		len_s2 <= len_s1;
		ctx_s3 <= ctx_s2;
		num_s3 <= 49'(a_s2) * 49'(HALF_PI_Q32);
		den_s3 <= len_s2;
	end

	// angle x = a * pi/2 / L in Q0.32
	logic             ang_v;
	logic [QUO_W-1:0] ang_quo;
	logic             ang_ovf;
	hta_ctx_t         ang_ctx;

	hta_div u_ang_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_num    (NUM_W'(num_s3)),
		.in_den    (DEN_W'(den_s3)),
		.in_ctx    (ctx_s3),
		.out_valid (ang_v),
		.out_quo   (ang_quo),
		.out_ovf   (ang_ovf),
		.out_ctx   (ang_ctx)
	);

	// hann factor from sin squared
	logic        sin_v;
	logic [24:0] sin_w;
	hta_ctx_t    sin_ctx;

	hta_sine u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ang_v & ~ang_ovf | ang_v),
		.in_x      (ang_quo[31:0]),
		.in_ctx    (ang_ctx),
		.out_valid (sin_v),
		.out_w     (sin_w),
		.out_ctx   (sin_ctx)
	);

	// stage 4: low-factor test, forward product, inverse numerator
	logic               v_s4;
	hta_ctx_t           ctx_s4;
	logic [56:0]        prod_s4;
	logic [NUM_W-1:0]   inum_s4;
	logic [DEN_W-1:0]   w_s4;
	hta_ctx_t           ctx4_c;

	always_comb begin
		ctx4_c     = sin_ctx;
		ctx4_c.low = sin_w <= LOW_FACTOR_MAX;
	end

	// stage 5: forward rounding and sign
	logic               v_s5;
	hta_ctx_t           ctx_s5;
	logic [NUM_W-1:0]   inum_s5;
	logic [DEN_W-1:0]   w_s5;
	logic [56:0]        rnd_c;
	logic [31:0]        fwd_c;
	hta_ctx_t           ctx5_c;

	always_comb begin
		rnd_c = (prod_s4 + (57'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		fwd_c = ctx_s4.neg ? 32'd0 - rnd_c[31:0] : rnd_c[31:0];
		ctx5_c     = ctx_s4;
		ctx5_c.fwd = fwd_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= sin_v;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s4     <= ctx4_c;
		prod_s4    <= 57'(sin_ctx.mag) * 57'(sin_w);
		inum_s4    <= {sin_ctx.mag, {FRAC_BITS{1'b0}}} + NUM_W'(sin_w[24:1]);
		w_s4       <= sin_w;
		ctx_s5     <= ctx5_c;
		inum_s5    <= inum_s4;
		w_s5       <= w_s4;
	end

	// inverse scaling, rounded quotient with overflow flag
	logic             inv_v;
	logic [QUO_W-1:0] inv_quo;
	logic             inv_ovf;
	hta_ctx_t         inv_ctx;

	hta_div u_inv_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_num    (inum_s5),
		.in_den    (w_s5),
		.in_ctx    (ctx_s5),
		.out_valid (inv_v),
		.out_quo   (inv_quo),
		.out_ovf   (inv_ovf),
		.out_ctx   (inv_ctx)
	);

	// final selection
	logic [QUO_W-1:0] lim_c, clip_c;
	logic             over_c;
	logic [31:0]      ival_c;
	hta_out_t         res_c;

	always_comb begin
		lim_c  = inv_ctx.neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		over_c = inv_ovf || (inv_quo > lim_c);
		clip_c = over_c ? lim_c : inv_quo;
		ival_c = inv_ctx.neg ? 32'd0 - clip_c[31:0] : clip_c[31:0];

		res_c.result_value   = inv_ctx.value;
		res_c.result_quality = inv_ctx.qual;
		res_c.result_bad     = inv_ctx.bad;
		res_c.saturated      = 1'b0;
		res_c.config_error   = inv_ctx.err;
		if (inv_ctx.act) begin
			if (!inv_ctx.inv) begin
				if (!inv_ctx.skip) res_c.result_value = inv_ctx.fwd;
			end else if (inv_ctx.low) begin
				// too small to divide by: mark the sample instead
				if (inv_ctx.qmode) begin
					if (!inv_ctx.db) res_c.result_quality = inv_ctx.qual | LOWAP_MASK;
				end else begin
					res_c.result_bad = 1'b1;
				end
			end else if (!inv_ctx.skip) begin
				res_c.result_value = ival_c;
				res_c.saturated    = over_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= inv_v;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_c;
	end

`ifndef SYNTH
	a_sat_only_inverse: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.saturated |-> inverse_q)
		else $error("saturation reported outside inverse mode");

	a_err_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.config_error |-> !result.saturated)
		else $error("saturation reported on a span error");

	a_done_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(inv_v))
		else $error("result strobe without an item leaving the pipe");
`endif

endmodule
`default_nettype wire
